// ===== rtl/b64enc_pkg.sv =====
// ----------------------------------------------------------------------------
// b64enc_pkg
// Shared types, constants and the character table of the base64 encoder.
// ----------------------------------------------------------------------------
package b64enc_pkg;

  // Default line length in characters when wrapping is enabled
  localparam int LINE_CHARS_DEF = 76;

  // Most characters one input byte can produce: line feed plus four
  localparam int MAX_CHARS = 5;
  localparam int IDX_W     = $clog2(MAX_CHARS);

  // Depth of the job queue between front and back
  localparam int QUEUE_DEPTH = 2;

  // Fixed character codes
  localparam logic [7:0] CHAR_LF    = 8'h0A;
  localparam logic [7:0] CHAR_PAD   = 8'h3D;
  localparam logic [7:0] CHAR_PLUS  = 8'h2B;
  localparam logic [7:0] CHAR_SLASH = 8'h2F;
  localparam logic [7:0] CHAR_UPPER = 8'h41;
  localparam logic [7:0] CHAR_LOWER = 8'h61;
  localparam logic [7:0] CHAR_DIGIT = 8'h30;

  // Position within the current 3-byte group
  typedef enum logic [2:0] {
    PH_FIRST  = 3'b001,
    PH_SECOND = 3'b010,
    PH_THIRD  = 3'b100
  } phase_t;

  // One byte's worth of output characters, handed from front to back
  typedef struct packed {
    logic [MAX_CHARS-1:0][7:0] chars;
    logic [IDX_W-1:0]          last_idx;
    logic                      last;
  } job_t;

  // Six-bit value to base64 alphabet character
  function automatic logic [7:0] b64_sym(input logic [5:0] v);
    logic [7:0] c;
    if (v < 6'd26) begin
      c = CHAR_UPPER + {2'b00, v};
    end else if (v < 6'd52) begin
      c = CHAR_LOWER + {2'b00, v} - 8'd26;
    end else if (v < 6'd62) begin
      c = CHAR_DIGIT + {2'b00, v} - 8'd52;
    end else if (v == 6'd62) begin
      c = CHAR_PLUS;
    end else begin
      c = CHAR_SLASH;
    end
    return c;
  endfunction

endpackage

// ===== rtl/base64_stream_encoder.sv =====
// ----------------------------------------------------------------------------
// base64_stream_encoder
// Streaming base64 encoder with optional line feeds every LINE_CHARS chars.
//
//   Channel  Signals                          Direction  Moves
//   cfg      cfg_valid cfg_ready wrap_lines   in         wrap enable bit
//   in       in_valid in_stall data_byte      in         one message byte
//            last_byte
//   out      out_valid out_stall out_char     out        one output character
//            last_char
//
// The back end emits one character per cycle while out_stall is low; a byte gives
// 1 to 5 characters (4 per 3 bytes plus line feeds).
// A byte can be taken every cycle while the 2-entry job queue has room.
// A byte's job is registered in the queue before its first character is registered at the output.
// rst is synchronous: clears encoder state, queue, output and wrap enable.
// in_stall follows the queue being full; out_stall only holds the back end.
// ----------------------------------------------------------------------------
module base64_stream_encoder #(
  parameter int LINE_CHARS = b64enc_pkg::LINE_CHARS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic       wrap_lines,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] data_byte,
  input  logic       last_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_char,
  output logic       last_char
);
  import b64enc_pkg::*;

  logic q_full;
  logic push;
  logic pop;
  logic head_valid;
  job_t new_job;
  job_t head_job;

  assign cfg_ready = 1'b1;
  assign in_stall  = q_full;

  // Byte front
  b64enc_front #(
    .LINE_CHARS (LINE_CHARS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .wrap_lines (wrap_lines),
    .in_valid   (in_valid),
    .q_full     (q_full),
    .data_byte  (data_byte),
    .last_byte  (last_byte),
    .push       (push),
    .job        (new_job)
  );

  // Job queue
  b64enc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_job   (new_job),
    .pop        (pop),
    .full       (q_full),
    .head_valid (head_valid),
    .head_job   (head_job)
  );

  // Character back end
  b64enc_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head_job   (head_job),
    .out_stall  (out_stall),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_char   (out_char),
    .last_char  (last_char)
  );

endmodule

// ===== rtl/b64enc_front.sv =====
// ----------------------------------------------------------------------------
// b64enc_front
// Accepts message bytes, tracks group phase and line fill, and turns each
// byte into a job listing the characters it produces.
// ----------------------------------------------------------------------------
module b64enc_front #(
  parameter int LINE_CHARS = b64enc_pkg::LINE_CHARS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_valid,
  input  logic              wrap_lines,
  input  logic              in_valid,
  input  logic              q_full,
  input  logic [7:0]        data_byte,
  input  logic              last_byte,
  output logic              push,
  output b64enc_pkg::job_t  job
);
  import b64enc_pkg::*;

  localparam int GROUP_LIMIT = (LINE_CHARS + 3) / 4;
  localparam int GOL_W       = $clog2(GROUP_LIMIT + 1);

  logic             wrap_en;
  phase_t           phase, phase_next;
  logic [3:0]       leftover, leftover_next;
  logic [GOL_W-1:0] groups_on_line, groups_on_line_next;
  logic             any_group_done, any_group_done_next;

  logic             feed;
  logic [7:0]       base [MAX_CHARS-1];
  logic [IDX_W-1:0] base_n;

  assign push = in_valid && !q_full;

  // Wrap register
  always_ff @(posedge clk) begin
    if (rst) begin
      wrap_en <= 1'b0;
    end else if (cfg_valid) begin
      wrap_en <= wrap_lines;
    end
  end

  // Characters and next state for the byte on the input
  always_comb begin
    phase_next          = phase;
    leftover_next       = leftover;
    groups_on_line_next = groups_on_line;
    any_group_done_next = any_group_done;
    feed                = 1'b0;
    base_n              = '0;
    for (int i = 0; i < MAX_CHARS - 1; i++) begin
      base[i] = CHAR_PAD;
    end

    case (phase)
      PH_FIRST: begin
        feed = wrap_en && any_group_done &&
               (groups_on_line >= GOL_W'(GROUP_LIMIT));
        if (feed) begin
          groups_on_line_next = '0;
        end
        base[0] = b64_sym(data_byte[7:2]);
        if (last_byte) begin
          base[1] = b64_sym({data_byte[1:0], 4'b0000});
          base_n  = IDX_W'(4);
        end else begin
          base_n        = IDX_W'(1);
          leftover_next = {2'b00, data_byte[1:0]};
          phase_next    = PH_SECOND;
        end
      end
      PH_SECOND: begin
        base[0] = b64_sym({leftover[1:0], data_byte[7:4]});
        if (last_byte) begin
          base[1] = b64_sym({data_byte[3:0], 2'b00});
          base_n  = IDX_W'(3);
        end else begin
          base_n        = IDX_W'(1);
          leftover_next = data_byte[3:0];
          phase_next    = PH_THIRD;
        end
      end
      default: begin
        base[0]             = b64_sym({leftover, data_byte[7:6]});
        base[1]             = b64_sym(data_byte[5:0]);
        base_n              = IDX_W'(2);
        phase_next          = PH_FIRST;
        leftover_next       = '0;
        any_group_done_next = 1'b1;
        if (groups_on_line < GOL_W'(GROUP_LIMIT)) begin
          groups_on_line_next = groups_on_line + GOL_W'(1);
        end
      end
    endcase

    // End of message returns everything to the start
    if (last_byte) begin
      phase_next          = PH_FIRST;
      leftover_next       = '0;
      groups_on_line_next = '0;
      any_group_done_next = 1'b0;
    end
  end

  // Job assembly: a line feed goes in front of the group's characters
  always_comb begin
    job.last = last_byte;
    if (feed) begin
      job.chars[0] = CHAR_LF;
      for (int i = 1; i < MAX_CHARS; i++) begin
        job.chars[i] = base[i-1];
      end
      job.last_idx = base_n;
    end else begin
      for (int i = 0; i < MAX_CHARS - 1; i++) begin
        job.chars[i] = base[i];
      end
      job.chars[MAX_CHARS-1] = CHAR_PAD;
      job.last_idx           = base_n - IDX_W'(1);
    end
  end

  // Encoder state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_FIRST;
      leftover       <= '0;
      groups_on_line <= '0;
      any_group_done <= 1'b0;
    end else if (push) begin
      phase          <= phase_next;
      leftover       <= leftover_next;
      groups_on_line <= groups_on_line_next;
      any_group_done <= any_group_done_next;
    end
  end

endmodule

// ===== rtl/b64enc_queue.sv =====
// ----------------------------------------------------------------------------
// b64enc_queue
// Short job queue decoupling the byte front from the character back.
// ----------------------------------------------------------------------------
module b64enc_queue #(
  parameter int DEPTH = b64enc_pkg::QUEUE_DEPTH
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  b64enc_pkg::job_t  push_job,
  input  logic              pop,
  output logic              full,
  output logic              head_valid,
  output b64enc_pkg::job_t  head_job
);
  import b64enc_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  job_t             slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_pop;

  assign full       = (count == CNT_W'(DEPTH));
  assign head_valid = (count != '0);
  assign head_job   = slots[rd_ptr];
  assign do_pop     = pop && head_valid;

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_job;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      case ({push, do_pop})
        2'b10:   count <= count + CNT_W'(1);
        2'b01:   count <= count - CNT_W'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== rtl/b64enc_back.sv =====
// ----------------------------------------------------------------------------
// b64enc_back
// Walks the head job one character per cycle, while not stalled, into the output register.
// ----------------------------------------------------------------------------
module b64enc_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              head_valid,
  input  b64enc_pkg::job_t  head_job,
  input  logic              out_stall,
  output logic              pop,
  output logic              out_valid,
  output logic [7:0]        out_char,
  output logic              last_char
);
  import b64enc_pkg::*;

  logic [IDX_W-1:0] idx;
  logic             load;
  logic             at_end;

  // Output register free, or being taken this cycle
  assign load   = !out_valid || !out_stall;
  assign at_end = (idx == head_job.last_idx);
  assign pop    = load && head_valid && at_end;

  // Character index within the head job
  always_ff @(posedge clk) begin
    if (rst) begin
      idx       <= '0;
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= head_valid;
      if (head_valid) begin
        idx <= at_end ? '0 : idx + IDX_W'(1);
      end
    end
  end

  // Output payload
  always_ff @(posedge clk) begin
    if (load && head_valid) begin
      out_char  <= head_job.chars[idx];
      last_char <= head_job.last && at_end;
    end
  end

endmodule

// ===== rtl/b64enc_checker.sv =====
// ----------------------------------------------------------------------------
// b64enc_checker
// Port-level checks on the base64 encoder, bound to the top level.
// ----------------------------------------------------------------------------
module b64enc_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] out_char,
  input logic       last_char
);
  import b64enc_pkg::*;

  // A stalled character holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_char) && $stable(last_char))
    else $error("output character changed while stalled");

  // Nothing leaves straight after reset
  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid after reset");

  // A byte transfer is followed by a valid output character
  a_byte_to_char: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> ##1 out_valid)
    else $error("no character after byte transfer");

  // A line feed never ends a message
  a_lf_not_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_char == CHAR_LF) |-> !last_char)
    else $error("line feed marked as last character");

endmodule

bind base64_stream_encoder b64enc_checker u_b64enc_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_char  (out_char),
  .last_char (last_char)
);

// ===== test/tb_base64_stream_encoder.sv =====
// ----------------------------------------------------------------------------
// tb_base64_stream_encoder
// Self-checking bench for the streaming base64 encoder. A predictor runs on
// every accepted byte and queues the characters it should produce; a checker
// compares each output transfer against the oldest queued character. Named
// tests cover padding and alphabet corners, line wrapping, a wrap change in
// the middle of a message, back-pressure and random messages.
// ----------------------------------------------------------------------------
module tb_base64_stream_encoder;
  timeunit 1ns;
  timeprecision 1ps;

  import b64enc_pkg::*;

  localparam int GROUPS_PER_LINE = (LINE_CHARS_DEF + 3) / 4;
  localparam int CYCLE_LIMIT     = 400_000;
  localparam int RANDOM_BYTES    = 20;
  localparam int NO_IDLE_BYTES   = 12;
  localparam int REPORT_MAX      = 10;

  typedef struct {
    logic [7:0] ch;
    logic       last;
  } enc_char_t;

  logic       clk        = 1'b0;
  logic       rst        = 1'b1;
  logic       cfg_valid  = 1'b0;
  logic       cfg_ready;
  logic       wrap_lines = 1'b0;
  logic       in_valid   = 1'b0;
  logic       in_stall;
  logic [7:0] data_byte  = 8'h00;
  logic       last_byte  = 1'b0;
  logic       out_valid;
  logic       out_stall  = 1'b0;
  logic [7:0] out_char;
  logic       last_char;

  // Predictor state
  logic       wrap_en;
  phase_t     enc_phase;
  logic [3:0] carry_bits;
  logic [4:0] line_groups;
  logic       group_seen;

  enc_char_t  expected_chars[$];
  string      b64_table =
    "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

  int mismatches   = 0;
  int cycle_count  = 0;
  int bytes_sent   = 0;
  int hold_left    = 0;
  bit tx_idle_en   = 1'b1;
  bit rx_idle_en   = 1'b1;

  base64_stream_encoder i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .wrap_lines(wrap_lines),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .data_byte (data_byte),
    .last_byte (last_byte),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_char  (out_char),
    .last_char (last_char)
  );

  always #5 clk = ~clk;

  // Run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Predictor
  // --------------------------------------------------------------------------
  function automatic logic [7:0] b64_char(input logic [5:0] v);
    return b64_table[v];
  endfunction

  task automatic queue_char(input logic [7:0] c, input logic l);
    enc_char_t e;
    e.ch   = c;
    e.last = l;
    expected_chars.push_back(e);
  endtask

  task automatic encode_byte(input logic [7:0] b, input logic l);
    case (enc_phase)
      PH_FIRST: begin
        // line feed only ahead of a group that starts on a full line
        if (wrap_en && group_seen && line_groups >= GROUPS_PER_LINE) begin
          queue_char(CHAR_LF, 1'b0);
          line_groups = '0;
        end
        queue_char(b64_char(b[7:2]), 1'b0);
        if (l) begin
          queue_char(b64_char({b[1:0], 4'b0000}), 1'b0);
          queue_char(CHAR_PAD, 1'b0);
          queue_char(CHAR_PAD, 1'b1);
        end else begin
          carry_bits = {2'b00, b[1:0]};
          enc_phase  = PH_SECOND;
        end
      end
      PH_SECOND: begin
        queue_char(b64_char({carry_bits[1:0], b[7:4]}), 1'b0);
        if (l) begin
          queue_char(b64_char({b[3:0], 2'b00}), 1'b0);
          queue_char(CHAR_PAD, 1'b1);
        end else begin
          carry_bits = b[3:0];
          enc_phase  = PH_THIRD;
        end
      end
      default: begin
        queue_char(b64_char({carry_bits, b[7:6]}), 1'b0);
        queue_char(b64_char(b[5:0]), l);
        enc_phase  = PH_FIRST;
        carry_bits = '0;
        if (line_groups < GROUPS_PER_LINE) line_groups = line_groups + 5'd1;
        group_seen = 1'b1;
      end
    endcase
    // end of message clears everything but the wrap setting
    if (l) begin
      enc_phase   = PH_FIRST;
      carry_bits  = '0;
      line_groups = '0;
      group_seen  = 1'b0;
    end
  endtask

  // Input side monitor: register writes and byte transfers
  always @(posedge clk) begin
    if (rst) begin
      wrap_en     = 1'b0;
      enc_phase   = PH_FIRST;
      carry_bits  = '0;
      line_groups = '0;
      group_seen  = 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) wrap_en = wrap_lines;
      if (in_valid && !in_stall) encode_byte(data_byte, last_byte);
    end
  end

  // --------------------------------------------------------------------------
  // Output checker
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    enc_char_t e;
    if (!rst && out_valid && !out_stall) begin
      if (expected_chars.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display("unexpected transfer: out_char=%h last_char=%b", out_char, last_char);
      end else begin
        e = expected_chars.pop_front();
        if (out_char !== e.ch || last_char !== e.last) begin
          mismatches++;
          if (mismatches <= REPORT_MAX)
            $display("mismatch: out_char exp %h got %h, last_char exp %b got %b",
                     e.ch, out_char, e.last, last_char);
        end
      end
    end
  end

  // Receiver: random stalls, plus a counted hold-off when requested
  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left = hold_left - 1;
    end else begin
      out_stall <= rx_idle_en && ($urandom_range(99) < 20);
    end
  end

  // --------------------------------------------------------------------------
  // Shared drivers
  // --------------------------------------------------------------------------

  // One byte transfer; valid stays high unless an idle gap follows
  task automatic send_byte(input logic [7:0] b, input logic l);
    int gap;
    gap = 0;
    in_valid  <= 1'b1;
    data_byte <= b;
    last_byte <= l;
    do @(posedge clk); while (in_stall);
    bytes_sent++;
    if (tx_idle_en)
      while ($urandom_range(99) < 20) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Random bytes; the final one optionally closes the message
  task automatic send_run(input int len, input bit close_msg);
    for (int i = 0; i < len; i++)
      send_byte(8'($urandom_range(255)), close_msg && (i == len - 1));
  endtask

  // Wait until every predicted character has come out
  task automatic drain;
    in_valid <= 1'b0;
    do @(posedge clk); while (expected_chars.size() != 0);
  endtask

  task automatic cfg_write(input logic v);
    drain();
    cfg_valid  <= 1'b1;
    wrap_lines <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Padding for every end phase, alphabet ends and byte extremes
  task automatic test_padding_and_alphabet;
    logic [7:0] pat [25] = '{
      8'h00,
      8'hFF,
      8'hFF, 8'h00,
      8'h00, 8'hFF, 8'h80,
      8'hFB, 8'hEF, 8'hBE,
      8'hFF, 8'hFF, 8'hFF,
      8'h4D, 8'h61, 8'h6E,
      8'h01, 8'h02, 8'h03, 8'h04,
      8'h80, 8'h7F, 8'h01, 8'hFE, 8'h55
    };
    int lens [9] = '{1, 1, 2, 3, 3, 3, 3, 4, 5};
    int k;
    k = 0;
    cfg_write(1'b0);
    for (int m = 0; m < 9; m++) begin
      for (int i = 0; i < lens[m]; i++) begin
        send_byte(pat[k], i == lens[m] - 1);
        k++;
      end
    end
    drain();
  endtask

  // One full line, then a line feed ahead of the padded last group
  task automatic test_line_wrap;
    cfg_write(1'b1);
    send_run(58, 1'b1);
    drain();
  endtask

  // Wrap toggled between bytes of one message; the line count keeps running
  // and saturates while wrapping is off
  task automatic test_wrap_mid_message;
    cfg_write(1'b1);
    send_run(30, 1'b0);
    cfg_write(1'b0);
    send_run(33, 1'b0);
    cfg_write(1'b1);
    send_run(6, 1'b1);
    drain();
  endtask

  // Receiver holds off while the sender keeps offering bytes
  task automatic test_back_pressure;
    tx_idle_en = 1'b0;
    hold_left  = 80;
    send_run(14, 1'b1);
    tx_idle_en = 1'b1;
    drain();
  endtask

  // Random short messages with random wrap settings
  task automatic test_random_messages;
    int start;
    int len;
    int pick;
    start = bytes_sent;
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    while (bytes_sent - start < RANDOM_BYTES) begin
      if (bytes_sent - start >= NO_IDLE_BYTES) begin
        tx_idle_en = 1'b1;
        rx_idle_en = 1'b1;
      end
      if ($urandom_range(99) < 25) cfg_write(1'($urandom_range(1)));
      pick = $urandom_range(99);
      if (pick < 15) len = $urandom_range(3, 1);
      else           len = $urandom_range(8, 1);
      send_run(len, 1'b1);
    end
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
    drain();
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    test_padding_and_alphabet();
    test_line_wrap();
    test_wrap_mid_message();
    test_back_pressure();
    test_random_messages();
    drain();
    // catch any stray character after the last expected one
    repeat (20) @(posedge clk);
    if (mismatches == 0 && expected_chars.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
